// ----- design/tva_pkg.sv -----
// Shared types, constants and saturation helper for the vertex bounding-box block.
package tva_pkg;

  localparam int COORD_W = 24;                  // signed Q16.8 coordinate width
  localparam int COEF_W  = 16;                  // signed Q2.14 coefficient width
  localparam int COEF_FRAC = 14;
  localparam int ROW_W   = 3 * COEF_W;          // packed matrix row
  localparam int PROD_W  = COORD_W + COEF_W;    // one coefficient times one coordinate
  localparam int SUM_W   = PROD_W + 2;          // sum of three products
  localparam int SHR_W   = SUM_W - COEF_FRAC;   // sum after the fraction shift
  localparam int QDEPTH  = 8;                   // words between front and back
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int OCC_W   = $clog2(QDEPTH + 1);

  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ROW_W-1:0] row_t;

  // register indexes, byte address 8*index
  typedef enum logic [2:0] {
    REG_ROT_ROW_X = 3'd0,
    REG_ROT_ROW_Y = 3'd1,
    REG_ROT_ROW_Z = 3'd2,
    REG_OFFSET_X  = 3'd3,
    REG_OFFSET_Y  = 3'd4,
    REG_OFFSET_Z  = 3'd5
  } reg_idx_t;

  localparam row_t ROT_ROW_X_RST = row_t'(48'd16384);
  localparam row_t ROT_ROW_Y_RST = row_t'(48'd16384 << COEF_W);
  localparam row_t ROT_ROW_Z_RST = row_t'(48'd16384 << (2 * COEF_W));

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    coord_t vert_x;
    coord_t vert_y;
    coord_t vert_z;
    logic   final_vertex;
  } vert_t;

  typedef struct packed {
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
  } box_t;

  // one transformed vertex, the word carried from front to back
  typedef struct packed {
    coord_t [2:0] coord;   // index 0 is x
    logic         final_vertex;
  } xfm_t;

  // clamp a wide signed value to the coordinate range
  function automatic coord_t sat_coord(input logic signed [SHR_W-1:0] v);
    coord_t r;
    r = v[COORD_W-1:0];
    if (v > SHR_W'(COORD_MAX)) r = COORD_MAX;
    else if (v < SHR_W'(COORD_MIN)) r = COORD_MIN;
    return r;
  endfunction

endpackage

// ----- design/tva_front.sv -----
// Front part: registers the vertex, multiplies by the rotation and saturates.
module tva_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_take,
  input  tva_pkg::vert_t              in_word,
  input  tva_pkg::row_t [2:0]         rot_row,
  output logic                        push,
  output tva_pkg::xfm_t               push_word
);
  import tva_pkg::*;

  logic                                s0_valid_r;
  vert_t                               s0_word_r;
  logic                                s1_valid_r;
  logic                                s1_final_r;
  logic signed [2:0][2:0][PROD_W-1:0]  prod_r;
  logic signed [2:0][2:0][PROD_W-1:0]  prod_nxt;
  logic                                s2_valid_r;
  xfm_t                                s2_word_r;
  xfm_t                                s2_word_nxt;

  always_comb begin
    coord_t [2:0] v;
    logic signed [COEF_W-1:0] k;
    v[0] = s0_word_r.vert_x;
    v[1] = s0_word_r.vert_y;
    v[2] = s0_word_r.vert_z;
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 3; c++) begin
        k = rot_row[a][COEF_W*c +: COEF_W];
        prod_nxt[a][c] = PROD_W'(k * v[c]);
      end
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] shr;
    s2_word_nxt.final_vertex = s1_final_r;
    for (int a = 0; a < 3; a++) begin
      acc = SUM_W'($signed(prod_r[a][0])) + SUM_W'($signed(prod_r[a][1])) +
            SUM_W'($signed(prod_r[a][2]));
      // arithmetic shift floors toward minus infinity
      shr = acc >>> COEF_FRAC;
      s2_word_nxt.coord[a] = sat_coord(shr[SHR_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= in_take;
      s1_valid_r <= s0_valid_r;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s0_word_r <= in_word;
    prod_r     <= prod_nxt;
    s1_final_r <= s0_word_r.final_vertex;
    s2_word_r  <= s2_word_nxt;
  end

  assign push      = s2_valid_r;
  assign push_word = s2_word_r;

endmodule

// ----- design/tva_queue.sv -----
// Short word queue between the transform front and the min/max back.
module tva_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tva_pkg::xfm_t  push_word,
  input  logic           pop,
  output logic           q_valid,
  output tva_pkg::xfm_t  q_word
);
  import tva_pkg::*;

  xfm_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [OCC_W-1:0]  count_r;
  logic [OCC_W-1:0]  count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + OCC_W'(1);
    else if (pop && !push) count_nxt = count_r - OCC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_word;
  end

  assign q_valid = (count_r != '0);
  assign q_word  = mem[rd_ptr_r];

endmodule

// ----- design/tva_back.sv -----
// Back part: folds transformed vertices into the running box and emits it.
module tva_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  tva_pkg::xfm_t         q_word,
  output logic                  pop,
  input  tva_pkg::coord_t [2:0] offset,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tva_pkg::box_t         out_data
);
  import tva_pkg::*;

  coord_t [2:0] run_lo_r;
  coord_t [2:0] run_hi_r;
  coord_t [2:0] lo_nxt;
  coord_t [2:0] hi_nxt;
  logic         crn_valid_r;
  coord_t [2:0] crn_lo_r;
  coord_t [2:0] crn_hi_r;
  logic         out_valid_r;
  box_t         out_data_r;
  box_t         out_data_nxt;
  logic         adv;

  // advance the whole back pipeline unless a result waits on a stalled receiver
  assign adv = !out_valid_r || !out_stall;
  assign pop = q_valid && adv;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo_nxt[a] = (q_word.coord[a] < run_lo_r[a]) ? q_word.coord[a] : run_lo_r[a];
      hi_nxt[a] = (q_word.coord[a] > run_hi_r[a]) ? q_word.coord[a] : run_hi_r[a];
    end
  end

  always_comb begin
    coord_t [2:0] lo_o;
    coord_t [2:0] hi_o;
    for (int a = 0; a < 3; a++) begin
      lo_o[a] = sat_coord(SHR_W'(crn_lo_r[a]) + SHR_W'(offset[a]));
      hi_o[a] = sat_coord(SHR_W'(crn_hi_r[a]) + SHR_W'(offset[a]));
    end
    out_data_nxt.box_min_x = lo_o[0];
    out_data_nxt.box_min_y = lo_o[1];
    out_data_nxt.box_min_z = lo_o[2];
    out_data_nxt.box_max_x = hi_o[0];
    out_data_nxt.box_max_y = hi_o[1];
    out_data_nxt.box_max_z = hi_o[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_lo_r    <= {3{COORD_MAX}};
      run_hi_r    <= {3{COORD_MIN}};
      crn_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= crn_valid_r;
      crn_valid_r <= pop && q_word.final_vertex;
      if (pop) begin
        if (q_word.final_vertex) begin
          run_lo_r <= {3{COORD_MAX}};
          run_hi_r <= {3{COORD_MIN}};
        end else begin
          run_lo_r <= lo_nxt;
          run_hi_r <= hi_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (pop) begin
        crn_lo_r <= lo_nxt;
        crn_hi_r <= hi_nxt;
      end
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/transformed_vertex_aabb.sv -----
// Top level: register file, front/back pipelines and queue for the vertex bounding box.
//
// Usage
//   Vertices arrive on the in_ channel, one word per cycle at most: signed Q16.8 x, y, z
//   and a final_vertex flag. A word moves when in_valid is high and in_stall is low.
//   Each vertex is rotated by the 3x3 Q2.14 matrix held in rot_row_x/y/z, floored,
//   clamped to 24 bits and folded into a running per-axis minimum and maximum.
//   On a vertex flagged final the offset registers are added to both corners with
//   clamping and one box word goes out on the out_ channel; the running box then
//   restarts empty. Other vertices produce no output.
//   A final vertex's box reaches out_ through the front stages, the queue, the
//   corner and output registers. Throughput: one vertex per cycle unless out_stall holds.
//   The front (input register, multiply stage, sum/clamp stage) never stops; an
//   eight-word queue decouples it from the back. in_stall rises when eight vertices
//   are accepted but not yet taken by the back, so the queue never overflows.
//   When out_stall holds a box, the back stops popping and the queue fills; the
//   output word holds steady until taken.
//   Reset (rst_n low, synchronous) restores identity rotation, zero offsets, an empty
//   box and an empty queue. Write registers over the APB port only while idle.
module transformed_vertex_aabb (
  input  logic                            clk,
  input  logic                            rst_n,
  // vertex channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tva_pkg::vert_t                  in_data,
  // box channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output tva_pkg::box_t                   out_data,
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tva_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tva_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tva_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import tva_pkg::*;

  row_t [2:0]       rot_row_r;
  coord_t [2:0]     offset_r;
  logic [2:0]       reg_sel;
  logic             cfg_wr;
  logic             in_take;
  logic             push;
  xfm_t             push_word;
  logic             pop;
  logic             q_valid;
  xfm_t             q_word;
  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;

  // ---------------- register file ----------------
  assign pready  = 1'b1;
  assign reg_sel = paddr[CFG_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_row_r[0] <= ROT_ROW_X_RST;
      rot_row_r[1] <= ROT_ROW_Y_RST;
      rot_row_r[2] <= ROT_ROW_Z_RST;
      offset_r     <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ROT_ROW_X: rot_row_r[0] <= pwdata[ROW_W-1:0];
        REG_ROT_ROW_Y: rot_row_r[1] <= pwdata[ROW_W-1:0];
        REG_ROT_ROW_Z: rot_row_r[2] <= pwdata[ROW_W-1:0];
        REG_OFFSET_X:  offset_r[0]  <= pwdata[COORD_W-1:0];
        REG_OFFSET_Y:  offset_r[1]  <= pwdata[COORD_W-1:0];
        REG_OFFSET_Z:  offset_r[2]  <= pwdata[COORD_W-1:0];
        default: ;  // drop writes past the last register
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ROT_ROW_X: prdata = CFG_DATA_W'(rot_row_r[0]);
      REG_ROT_ROW_Y: prdata = CFG_DATA_W'(rot_row_r[1]);
      REG_ROT_ROW_Z: prdata = CFG_DATA_W'(rot_row_r[2]);
      REG_OFFSET_X:  prdata = CFG_DATA_W'(offset_r[0]);
      REG_OFFSET_Y:  prdata = CFG_DATA_W'(offset_r[1]);
      REG_OFFSET_Z:  prdata = CFG_DATA_W'(offset_r[2]);
      default:       prdata = '0;
    endcase
  end

  // ---------------- admission ----------------
  // Count words accepted but not yet popped by the back; this covers the front
  // stages and the queue, so a full count means the queue could overflow.
  assign in_stall = (occ_r >= OCC_W'(QDEPTH));
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    occ_nxt = occ_r;
    if (in_take && !pop) occ_nxt = occ_r + OCC_W'(1);
    else if (pop && !in_take) occ_nxt = occ_r - OCC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) occ_r <= '0;
    else        occ_r <= occ_nxt;
  end

  // ---------------- datapath ----------------
  tva_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_word   (in_data),
    .rot_row   (rot_row_r),
    .push      (push),
    .push_word (push_word)
  );

  tva_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_word    (q_word)
  );

  tva_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .pop       (pop),
    .offset    (offset_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the transformed-vertex bounding-box block.
`timescale 1ns / 100ps

module tb;
  import tva_pkg::*;

  // Run shape: a directed opener, then random phases that each end on a final
  // vertex, so the block is idle whenever the registers are reprogrammed.
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 145;
  localparam int DRAIN_CYCLES    = 20;         // margin well beyond the pipeline depth
  localparam int TIMEOUT_NS      = 4_000_000;  // clock period is 20 ns

  // Register slots past the offsets: writes there must be dropped.
  localparam logic [2:0] SPARE_REG_LO = 3'd6;
  localparam logic [2:0] SPARE_REG_HI = 3'd7;

  // Q2.14 coefficients of interest.
  localparam logic [COEF_W-1:0] COEF_ZERO    = 16'h0000;
  localparam logic [COEF_W-1:0] COEF_ONE     = 16'h4000;
  localparam logic [COEF_W-1:0] COEF_NEG_ONE = 16'hC000;
  localparam logic [COEF_W-1:0] COEF_TOP     = 16'h7FFF;
  localparam logic [COEF_W-1:0] COEF_BOTTOM  = 16'h8000;

  // Bounding-box predictor: rotation, clamping, running min/max and offset,
  // plus the queue of boxes the block still owes us.
  class box_scoreboard;
    row_t   rows[3];
    coord_t offs[3];
    coord_t lo[3];
    coord_t hi[3];
    box_t   boxes_due[$];
    int     mismatches;
    int     vertices;
    int     boxes_checked;
    string  field_name[6] = '{"box_max_z", "box_max_y", "box_max_x",
                              "box_min_z", "box_min_y", "box_min_x"};

    function new();
      rows[0] = ROT_ROW_X_RST;
      rows[1] = ROT_ROW_Y_RST;
      rows[2] = ROT_ROW_Z_RST;
      foreach (offs[a]) offs[a] = '0;
      restart_box();
    endfunction

    function void restart_box();
      foreach (lo[a]) begin
        lo[a] = COORD_MAX;
        hi[a] = COORD_MIN;
      end
    endfunction

    function coord_t clamp(longint v);
      if (v > longint'(COORD_MAX)) return COORD_MAX;
      if (v < longint'(COORD_MIN)) return COORD_MIN;
      return coord_t'(v);
    endfunction

    function void set_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx) inside
        REG_ROT_ROW_X, REG_ROT_ROW_Y, REG_ROT_ROW_Z: begin
          rows[idx] = value[ROW_W-1:0];
        end
        REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z: begin
          offs[idx - REG_OFFSET_X] = value[COORD_W-1:0];
        end
        default: ;  // unmapped slot: write is dropped
      endcase
    endfunction

    // Fold one accepted vertex; a final vertex closes the box.
    function void note_vertex(vert_t v);
      longint pos[3];
      longint acc;
      coord_t t;
      box_t   b;
      pos[0] = v.vert_x;
      pos[1] = v.vert_y;
      pos[2] = v.vert_z;
      for (int a = 0; a < 3; a++) begin
        acc = 0;
        for (int i = 0; i < 3; i++)
          acc += longint'($signed(rows[a][COEF_W*i +: COEF_W])) * pos[i];
        t = clamp(acc >>> COEF_FRAC);  // arithmetic shift floors toward minus infinity
        if (t < lo[a]) lo[a] = t;
        if (t > hi[a]) hi[a] = t;
      end
      vertices++;
      if (v.final_vertex) begin
        b.box_min_x = clamp(longint'(lo[0]) + offs[0]);
        b.box_min_y = clamp(longint'(lo[1]) + offs[1]);
        b.box_min_z = clamp(longint'(lo[2]) + offs[2]);
        b.box_max_x = clamp(longint'(hi[0]) + offs[0]);
        b.box_max_y = clamp(longint'(hi[1]) + offs[1]);
        b.box_max_z = clamp(longint'(hi[2]) + offs[2]);
        boxes_due.push_back(b);
        restart_box();
      end
    endfunction

    function int pending();
      return boxes_due.size();
    endfunction

    task flag(string what);
      $display("tb: mismatch: %s", what);
      mismatches++;
    endtask

    task check_box(box_t got);
      box_t exp_box;
      coord_t [5:0] g;
      coord_t [5:0] e;
      if (boxes_due.size() == 0) begin
        flag("box word arrived with none due");
        return;
      end
      exp_box = boxes_due.pop_front();
      g = got;
      e = exp_box;
      for (int f = 0; f < 6; f++)
        if (g[f] !== e[f])
          flag($sformatf("box %0d %s got %0d want %0d",
                         boxes_checked, field_name[f], g[f], e[f]));
      boxes_checked++;
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  vert_t                 in_data;
  logic                  out_valid;
  logic                  out_stall;
  box_t                  out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  box_scoreboard sb = new();
  int in_idle_pct;   // chance in a hundred that the sender skips a cycle
  int stall_pct;     // chance in a hundred that the receiver stalls a cycle
  int reg_ops;
  int meshes;

  transformed_vertex_aabb dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("tb: FAIL");
    $finish;
  end

  // Receiver: stall at random per phase, changing only on the falling edge.
  always @(negedge clk)
    out_stall <= ($urandom_range(0, 99) < stall_pct);

  // Check every box word the moment it is taken.
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      sb.check_box(out_data);

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3: return coord_t'(int'($urandom_range(0, 4095)) - 2048);  // near the origin
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return COEF_ONE;
      1: return COEF_NEG_ONE;
      2: return COEF_ZERO;
      3: return COEF_TOP;
      4: return COEF_BOTTOM;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic coord_t rand_offset();
    case ($urandom_range(0, 7))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      3: return coord_t'(int'($urandom_range(0, 255)) - 128);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Send one vertex word: idle at random first, then hold it until taken.
  task push_vertex(coord_t x, coord_t y, coord_t z, logic last);
    vert_t v;
    v.vert_x = x;
    v.vert_y = y;
    v.vert_z = z;
    v.final_vertex = last;
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= v;
    do @(posedge clk); while (in_stall);
    sb.note_vertex(v);
    if (last) meshes++;
  endtask

  // Drop valid, let every owed box come out, then give the pipe time to empty.
  task settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready.
  task reg_write(logic [2:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    reg_ops++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task reg_read(logic [2:0] idx, output logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    reg_ops++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Read back all six registers; compare only the bits each one holds.
  task check_regs();
    logic [CFG_DATA_W-1:0] got;
    for (int i = REG_ROT_ROW_X; i <= REG_OFFSET_Z; i++) begin
      reg_read(3'(i), got);
      if (i < REG_OFFSET_X) begin
        if (got[ROW_W-1:0] !== sb.rows[i])
          sb.flag($sformatf("reg %0d read %h want %h", i, got[ROW_W-1:0], sb.rows[i]));
      end else if (got[COORD_W-1:0] !== sb.offs[i - REG_OFFSET_X]) begin
        sb.flag($sformatf("reg %0d read %h want %h", i, got[COORD_W-1:0],
                          sb.offs[i - REG_OFFSET_X]));
      end
    end
  endtask

  // Program all three rows and offsets; junk goes in the unused upper bits.
  task program_all(row_t rx, row_t ry, row_t rz, coord_t ox, coord_t oy, coord_t oz);
    reg_write(REG_ROT_ROW_X, {16'($urandom), rx});
    reg_write(REG_ROT_ROW_Y, {16'($urandom), ry});
    reg_write(REG_ROT_ROW_Z, {16'($urandom), rz});
    reg_write(REG_OFFSET_X, {32'($urandom), 8'($urandom), ox});
    reg_write(REG_OFFSET_Y, {32'($urandom), 8'($urandom), oy});
    reg_write(REG_OFFSET_Z, {32'($urandom), 8'($urandom), oz});
    check_regs();
  endtask

  initial begin
    int len;
    int sent;
    row_t rx, ry, rz;

    // Every input known from time zero; hold reset, then release it on a falling edge.
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_idle_pct = 0;
    stall_pct   = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);

    // ---- Directed opener, both sides streaming flat out ----
    check_regs();  // reset values

    // Identity rotation: one-vertex meshes give a box with min equal to max.
    push_vertex(COORD_MAX, COORD_MIN, coord_t'(0), 1'b1);
    push_vertex(COORD_MIN, COORD_MAX, coord_t'(-1), 1'b1);
    push_vertex(coord_t'(100), coord_t'(-200), coord_t'(300), 1'b0);
    push_vertex(coord_t'(-5), coord_t'(7), COORD_MAX, 1'b0);
    push_vertex(coord_t'(0), coord_t'(0), COORD_MIN, 1'b1);
    settle();

    // Writes to the unmapped slots must leave every register alone.
    reg_write(SPARE_REG_LO, '1);
    reg_write(SPARE_REG_HI, {$urandom, $urandom});
    check_regs();

    // Full-scale positive coefficients: the rotation clamps, and so does the
    // offset sum at the top end.
    program_all({3{COEF_TOP}}, {3{COEF_TOP}}, {3{COEF_TOP}}, COORD_MAX, COORD_MAX, COORD_MAX);
    push_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    push_vertex(coord_t'(1), coord_t'(1), coord_t'(1), 1'b0);
    push_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    push_vertex(coord_t'(1), coord_t'(-1), coord_t'(1), 1'b1);
    settle();

    // Most negative coefficients with the lowest offset: clamp at the bottom.
    program_all({3{COEF_BOTTOM}}, {3{COEF_BOTTOM}}, {3{COEF_BOTTOM}},
                COORD_MIN, COORD_MIN, COORD_MIN);
    push_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    push_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    push_vertex(coord_t'(-1), coord_t'(0), coord_t'(1), 1'b1);
    settle();

    // Mirror on every axis, small offsets.
    program_all({COEF_ZERO, COEF_ZERO, COEF_NEG_ONE}, {COEF_ZERO, COEF_NEG_ONE, COEF_ZERO},
                {COEF_NEG_ONE, COEF_ZERO, COEF_ZERO},
                coord_t'(12), coord_t'(-34), coord_t'(56));
    push_vertex(coord_t'(3), coord_t'(-3), coord_t'(255), 1'b0);
    push_vertex(COORD_MIN, COORD_MAX, coord_t'(-77), 1'b1);

    // ---- Random phases: new registers each time, idling pattern rotates ----
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          rx = ROT_ROW_X_RST;
          ry = ROT_ROW_Y_RST;
          rz = ROT_ROW_Z_RST;
        end
        1: begin
          rx = {3{COEF_TOP}};
          ry = {3{COEF_BOTTOM}};
          rz = {COEF_TOP, COEF_BOTTOM, COEF_ONE};
        end
        default: begin
          rx = {rand_coef(), rand_coef(), rand_coef()};
          ry = {rand_coef(), rand_coef(), rand_coef()};
          rz = {rand_coef(), rand_coef(), rand_coef()};
        end
      endcase
      program_all(rx, ry, rz, rand_offset(), rand_offset(), rand_offset());

      case (ph % 4)
        0: begin in_idle_pct = 0;  stall_pct = 0;  end
        1: begin in_idle_pct = 65; stall_pct = 0;  end
        2: begin in_idle_pct = 0;  stall_pct = 65; end
        default: begin in_idle_pct = 16; stall_pct = 16; end
      endcase

      // Meshes are mostly short so boxes come often; now and then a long one.
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        for (int j = 0; j < len; j++)
          push_vertex(rand_coord(), rand_coord(), rand_coord(), j == len - 1);
        sent += len;
      end
    end

    // Wait out the last boxes, then let the pipe go quiet.
    settle();

    $display("tb: %0d vertices in %0d meshes, %0d boxes checked, %0d register accesses",
             sb.vertices, meshes, sb.boxes_checked, reg_ops);
    $display("tb: %0d phases over identity, full-scale and random rotations", PHASES);
    if (sb.mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/tva_pkg.sv
design/tva_front.sv
design/tva_queue.sv
design/tva_back.sv
design/transformed_vertex_aabb.sv
verif/tb.sv
